// File: rtl/mf3s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3s_pkg: shared types and constants of the 3x3 median filter
// Field widths, register codes, pipeline records and the 19-exchange
// median sorting network.
// ----------------------------------------------------------------------------
package mf3s_pkg;

  // Field widths
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned FW_W       = 9;
  localparam int unsigned FH_W       = 12;
  localparam int unsigned CFG_DATA_W = 12;

  // Line buffer depth default
  localparam int unsigned MAX_WIDTH_DEF = 256;

  // Register reset values and smallest frame dimension
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd192;
  localparam int unsigned     MIN_DIM          = 3;

  // Result slots of one input item, in emission order
  localparam int unsigned RES_NEIGH    = 0;  // pixel one row and one column behind
  localparam int unsigned RES_ROW_END  = 1;  // last column of the row above
  localparam int unsigned RES_LAST_ROW = 2;  // input pixel itself on the last row
  localparam int unsigned NUM_RES      = 3;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef pixel_t [8:0]     window_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item record carried down the pipeline
  typedef struct packed {
    pixel_t             pix;     // input pixel
    pixel_t             mid;     // line buffer pixel one row above
    pixel_t             ctr;     // window center, used for border copies
    col_t               col;     // input column
    col_t               wcol;    // last column of the frame
    row_t               row;     // input row
    logic [NUM_RES-1:0] emit;    // which results this item gives
    logic               border;  // neighborhood result is a border pixel
  } meta_t;

  typedef struct packed {
    pixel_t pix;
    col_t   col;
    row_t   row;
  } result_t;

  typedef struct packed {
    logic [NUM_RES-1:0]    emit;
    result_t [NUM_RES-1:0] res;
  } result_set_t;

  // Median sorting network: 19 compare-exchange pairs
  localparam int unsigned NUM_EX = 19;
  localparam logic [3:0] EX_A [NUM_EX] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] EX_B [NUM_EX] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  // Network split over spans SORT1, SORT2 and SORT3; the last is combinational
  localparam int unsigned SORT1_FIRST = 0;
  localparam int unsigned SORT1_LAST  = 8;
  localparam int unsigned SORT2_FIRST = 9;
  localparam int unsigned SORT2_LAST  = 14;
  localparam int unsigned SORT3_FIRST = 15;
  localparam int unsigned SORT3_LAST  = 18;
  localparam int unsigned MEDIAN_POS  = 4;

  // Apply the exchanges first_ex..last_ex of the network
  function automatic window_t exchange_span(window_t v, int unsigned first_ex,
                                            int unsigned last_ex);
    window_t w;
    pixel_t  t;
    w = v;
    for (int unsigned i = 0; i < NUM_EX; i++) begin
      if (i >= first_ex && i <= last_ex && w[EX_A[i]] > w[EX_B[i]]) begin
        t          = w[EX_A[i]];
        w[EX_A[i]] = w[EX_B[i]];
        w[EX_B[i]] = t;
      end
    end
    return w;
  endfunction

endpackage

// File: rtl/mf3s_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3s_if: stream and configuration channels of the 3x3 median filter
// Valid/ready channels for input pixels, results and register writes.
// ----------------------------------------------------------------------------
interface mf3s_pix_if;
  logic                valid;
  logic                ready;
  mf3s_pkg::pixel_t    pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3s_res_if;
  logic                valid;
  logic                ready;
  mf3s_pkg::pixel_t    pixel_out;
  mf3s_pkg::col_t      out_col;
  mf3s_pkg::row_t      out_row;
  logic                last_of_run;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output last_of_run, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input last_of_run, output ready);
endinterface

interface mf3s_cfg_if;
  logic                                valid;
  logic                                ready;
  mf3s_pkg::cfg_reg_e                  index;
  logic [mf3s_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mf3s_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3s_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mf3s_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/mf3s_out_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3s_out_seq: result register and output sequencer
// Holds the up to three results of one item and hands them out in order,
// one transaction per cycle while out_o.ready holds, marking the run's last.
// ----------------------------------------------------------------------------
module mf3s_out_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mf3s_pkg::result_set_t set_i,
  output logic                  free_o,
  mf3s_res_if.source            out_o
);

  logic [mf3s_pkg::NUM_RES-1:0]    emit_q, emit_d;
  mf3s_pkg::result_t [mf3s_pkg::NUM_RES-1:0] res_q;
  logic [1:0]                      sel;
  logic                            last;
  logic                            out_acc;
  mf3s_pkg::result_t               pick;

  // Pick the earliest pending result
  always_comb begin
    priority if (emit_q[mf3s_pkg::RES_NEIGH]) begin
      sel = 2'(mf3s_pkg::RES_NEIGH);
    end else if (emit_q[mf3s_pkg::RES_ROW_END]) begin
      sel = 2'(mf3s_pkg::RES_ROW_END);
    end else begin
      sel = 2'(mf3s_pkg::RES_LAST_ROW);
    end
  end

  assign pick    = res_q[sel];
  assign last    = (emit_q & (emit_q - 3'd1)) == 3'd0;
  assign out_acc = out_o.valid && out_o.ready;

  assign out_o.valid       = |emit_q;
  assign out_o.pixel_out   = pick.pix;
  assign out_o.out_col     = pick.col;
  assign out_o.out_row     = pick.row;
  assign out_o.last_of_run = last;

  // Free when empty or when the final pending result leaves now
  assign free_o = (emit_q == 3'd0) || (last && out_o.ready);

  // Load a new set, or drop the result just taken
  always_comb begin
    emit_d = emit_q;
    if (load_i) begin
      emit_d = set_i.emit;
    end else if (out_acc) begin
      emit_d = emit_q & ~(3'b001 << sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= '0;
    end else begin
      emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= set_i.res;
    end
  end

endmodule

// File: rtl/median_filter_3x3_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_top: streaming 3x3 median filter
// Raster-order 16-bit pixels in, median-filtered pixels with coordinates out.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output side holds it. Each
// pixel passes a five-register pipeline (line buffer read, window, two
// sorting stages, result register). Line buffers are one dual-port RAM of
// MAX_WIDTH words of 32 bits, read and written once per pixel. The output
// channel carries one result per cycle while the receiver is ready; a pixel
// giving two or three results (the last column of a row below the first, and
// every pixel of the last row but its first) holds the input while its extra
// results leave. Frame width and height must be written by the user only
// while no pixel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_top #(
  parameter int unsigned MAX_WIDTH = mf3s_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mf3s_pix_if.sink    in_i,
  mf3s_res_if.source  out_o,
  mf3s_cfg_if.sink    cfg_i
);

  localparam int unsigned ColCntW = $clog2(MAX_WIDTH);
  localparam int unsigned WidW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW    = (WidW > mf3s_pkg::FW_W) ? WidW : mf3s_pkg::FW_W;
  localparam int unsigned ColW    = mf3s_pkg::COL_W;
  localparam int unsigned RowW    = mf3s_pkg::ROW_W;
  localparam int unsigned FhW     = mf3s_pkg::FH_W;
  localparam int unsigned PixW    = mf3s_pkg::PIX_W;

  // Configuration registers
  logic [mf3s_pkg::FW_W-1:0] frame_width_q;
  logic [FhW-1:0]            frame_height_q;

  // Position counters
  logic [ColCntW-1:0] col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;

  // Effective frame limits
  logic [CmpW-1:0]    fw_x, w_eff_x;
  logic [ColCntW-1:0] w_last;
  logic [FhW-1:0]     h_last;
  logic               col_at_end, row_at_end;

  // Pipeline control
  logic in_acc;
  logic rdy1, rdy2, rdy3, rdy4, free;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  // Pipeline payload
  mf3s_pkg::meta_t   in_meta;
  mf3s_pkg::meta_t   s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q;
  mf3s_pkg::meta_t   s2_meta_d, s3_meta_d;
  logic [ColCntW-1:0] s1_addr_q;
  mf3s_pkg::window_t win_q, win_d;
  mf3s_pkg::window_t s3_sort_q, s4_sort_q, sorted;

  // Line buffer RAM: upper half older row, lower half newer row
  logic              lb_we;
  logic [2*PixW-1:0] lb_rdata;
  mf3s_pkg::pixel_t  lb_top, lb_mid;

  mf3s_pkg::result_set_t res_set;
  logic                  load;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mf3s_pkg::FRAME_WIDTH_RST;
      frame_height_q <= mf3s_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mf3s_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[mf3s_pkg::FW_W-1:0];
        mf3s_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[FhW-1:0];
      endcase
    end
  end

  // Clamp the frame size to the supported range
  always_comb begin
    fw_x = CmpW'(frame_width_q);
    priority if (fw_x < CmpW'(mf3s_pkg::MIN_DIM)) begin
      w_eff_x = CmpW'(mf3s_pkg::MIN_DIM);
    end else if (fw_x > CmpW'(MAX_WIDTH)) begin
      w_eff_x = CmpW'(MAX_WIDTH);
    end else begin
      w_eff_x = fw_x;
    end
  end

  assign w_last = ColCntW'(w_eff_x - CmpW'(1));
  assign h_last = (frame_height_q < FhW'(mf3s_pkg::MIN_DIM))
                ? FhW'(mf3s_pkg::MIN_DIM - 1) : frame_height_q - FhW'(1);

  assign col_at_end = col_q >= w_last;
  assign row_at_end = row_q >= h_last;

  // -------------------------------------------------------- handshake chain
  assign rdy4   = !s4_valid_q || free;
  assign rdy3   = !s3_valid_q || rdy4;
  assign rdy2   = !s2_valid_q || rdy3;
  assign rdy1   = !s1_valid_q || rdy2;
  assign in_i.ready = rdy1;
  assign in_acc = in_i.valid && rdy1;
  assign load   = s4_valid_q && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_i.valid;
      if (rdy2) s2_valid_q <= s1_valid_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
      if (rdy4) s4_valid_q <= s3_valid_q;
    end
  end

  // ------------------------------------------------------ position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_at_end) begin
        col_d = '0;
        row_d = row_at_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Decide at entry which results the item gives
  always_comb begin
    in_meta        = '0;
    in_meta.pix    = in_i.pixel_in;
    in_meta.col    = ColW'(col_q);
    in_meta.wcol   = ColW'(w_last);
    in_meta.row    = row_q;
    in_meta.emit[mf3s_pkg::RES_NEIGH]    = (row_q != '0) && (col_q != '0);
    in_meta.emit[mf3s_pkg::RES_ROW_END]  = (row_q != '0) && col_at_end;
    in_meta.emit[mf3s_pkg::RES_LAST_ROW] = row_at_end;
    in_meta.border = (col_q == ColCntW'(1)) || (row_q == RowW'(1))
                   || (col_q > w_last) || (row_q > h_last);
  end

  // --------------------------------------------------------- line buffers
  assign lb_top = lb_rdata[2*PixW-1:PixW];
  assign lb_mid = lb_rdata[PixW-1:0];
  assign lb_we  = s1_valid_q && rdy2;

  mf3s_ram #(
    .WIDTH (2 * PixW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (s1_addr_q),
    .wdata_i ({lb_mid, s1_meta_q.pix}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (lb_rdata)
  );

  // Stage 1: hold the item while its line buffer read completes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_meta_q <= in_meta;
      s1_addr_q <= col_q;
    end
  end

  // Stage 2: shift the window one column left
  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = lb_top;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = lb_mid;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_meta_q.pix;
  end

  // Attach the line buffer pixel one row above
  always_comb begin
    s2_meta_d     = s1_meta_q;
    s2_meta_d.mid = lb_mid;
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      win_q     <= win_d;
      s2_meta_q <= s2_meta_d;
    end
  end

  // Stage 3: first three levels of the sorting network
  always_comb begin
    s3_meta_d     = s2_meta_q;
    s3_meta_d.ctr = win_q[mf3s_pkg::MEDIAN_POS];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_valid_q) begin
      s3_sort_q <= mf3s_pkg::exchange_span(win_q, mf3s_pkg::SORT1_FIRST,
                                           mf3s_pkg::SORT1_LAST);
      s3_meta_q <= s3_meta_d;
    end
  end

  // Stage 4: middle levels of the sorting network
  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_valid_q) begin
      s4_sort_q <= mf3s_pkg::exchange_span(s3_sort_q, mf3s_pkg::SORT2_FIRST,
                                           mf3s_pkg::SORT2_LAST);
      s4_meta_q <= s3_meta_q;
    end
  end

  // Finish the network and assemble the results
  assign sorted = mf3s_pkg::exchange_span(s4_sort_q, mf3s_pkg::SORT3_FIRST,
                                          mf3s_pkg::SORT3_LAST);

  always_comb begin
    res_set      = '0;
    res_set.emit = s4_meta_q.emit;

    res_set.res[mf3s_pkg::RES_NEIGH].pix = s4_meta_q.border
                                         ? s4_meta_q.ctr : sorted[mf3s_pkg::MEDIAN_POS];
    res_set.res[mf3s_pkg::RES_NEIGH].col = s4_meta_q.col - ColW'(1);
    res_set.res[mf3s_pkg::RES_NEIGH].row = s4_meta_q.row - RowW'(1);

    res_set.res[mf3s_pkg::RES_ROW_END].pix = s4_meta_q.mid;
    res_set.res[mf3s_pkg::RES_ROW_END].col = s4_meta_q.wcol;
    res_set.res[mf3s_pkg::RES_ROW_END].row = s4_meta_q.row - RowW'(1);

    res_set.res[mf3s_pkg::RES_LAST_ROW].pix = s4_meta_q.pix;
    res_set.res[mf3s_pkg::RES_LAST_ROW].col = s4_meta_q.col;
    res_set.res[mf3s_pkg::RES_LAST_ROW].row = s4_meta_q.row;
  end

  // ------------------------------------------------------------ output side
  mf3s_out_seq u_out_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .set_i  (res_set),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// File: rtl/mf3s_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3s_checker: port-level checks of the 3x3 median filter
// Watches the result channel for hold behavior, row range and run shape.
// ----------------------------------------------------------------------------
module mf3s_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input mf3s_pkg::pixel_t pixel_out_i,
  input mf3s_pkg::col_t   out_col_i,
  input mf3s_pkg::row_t   out_row_i,
  input logic             last_of_run_i
);

  logic           out_acc;
  logic [1:0]     run_cnt_q;
  mf3s_pkg::row_t prev_row_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Track position inside a run of results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else if (out_acc) begin
      run_cnt_q <= last_of_run_i ? 2'd0 : run_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      prev_row_q <= out_row_i;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pixel_out_i) && $stable(out_col_i)
                                     && $stable(out_row_i) && $stable(last_of_run_i))
    else $error("result payload changed while stalled");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_row_i != 12'hFFF)
    else $error("result row underflowed");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_run_i |-> run_cnt_q < 2'd2)
    else $error("run of results longer than three");

  a_run_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && run_cnt_q != 2'd0 |->
      out_row_i == prev_row_q || out_row_i == prev_row_q + 12'd1)
    else $error("rows inside one run are not adjacent");

endmodule

bind median_filter_3x3_stream_top mf3s_checker u_mf3s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_out_i   (out_o.pixel_out),
  .out_col_i     (out_o.out_col),
  .out_row_i     (out_o.out_row),
  .last_of_run_i (out_o.last_of_run)
);
